// ===== rtl/mcao_pkg.sv =====
// Package for the multichannel converter oversampler: word structs, per-channel
// table entry, sequencer states and register indexes.
// No dependencies; imported by multichannel_adc_oversampler.
`timescale 1ns / 1ps

package mcao_pkg;

  localparam int unsigned CH_W    = 3;
  localparam int unsigned SMP_W   = 12;
  localparam int unsigned RED_W   = 8;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned RD_W    = 14;
  localparam int unsigned WIN_W   = 9;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned RBITS_W = 4;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned IDX_W   = 2;
  // dividend is sum * 4
  localparam int unsigned QUO_W   = SUM_W + 2;
  localparam int unsigned STEP_W  = $clog2(QUO_W);
  localparam logic [RD_W-1:0] RD_MAX = '1;
  localparam logic [RBITS_W-1:0] RBITS_MAX = RBITS_W'(RD_W);

  typedef enum logic [IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_FAST_MASK     = 2'd1,
    REG_ENABLED_MASK  = 2'd2,
    REG_RESULT_BITS   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_channel;
    logic [SUM_W-1:0] window_sum;
    logic [RD_W-1:0]  scaled_reading;
    logic [RED_W-1:0] sample_range;
  } out_word_t;

  typedef struct packed {
    logic [WIN_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [RED_W-1:0] high;
    logic [RED_W-1:0] low;
  } chan_entry_t;

  localparam chan_entry_t ENTRY_CLEAR = '{count: '0, sum: '0, high: '0, low: '1};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DIV,
    ST_DONE
  } seq_state_e;

endpackage

// ===== rtl/multichannel_adc_oversampler.sv =====
// Multichannel converter oversampler: per-channel window accumulation with a
// shared bit-serial divider for the scaled reading. Depends on mcao_pkg.
//
//   port group   dir  handshake              payload
//   in           in   in_valid_i/in_ready_o   in_word_i  (channel, sample)
//   out          out  out_valid_o/out_ready_i out_word_o (channel, sum, reading, range)
//   cfg          in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// A word that only accumulates, or is ignored, passes ST_IDLE (accept) and
// ST_LOOK (table update); one that closes a window also passes ST_DIV, where the
// restoring divider retires one quotient bit a cycle over the 22-bit dividend,
// and ST_DONE. Reset clears the channel table and output valid flag and sets the
// config defaults. The result waits in the output register; the next word is
// taken meanwhile, and only a second window end stalls until the first is taken.
`timescale 1ns / 1ps

module multichannel_adc_oversampler
  import mcao_pkg::*;
#(
  parameter int unsigned CHANNELS   = 8,
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_word_t                in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_word_t               out_word_o,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned CI_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // config registers
  logic [WIN_W-1:0]   win_len_q;
  logic [MASK_W-1:0]  fast_mask_q;
  logic [MASK_W-1:0]  en_mask_q;
  logic [RBITS_W-1:0] rbits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= WIN_W'(1);
      fast_mask_q <= '0;
      en_mask_q   <= '0;
      rbits_q     <= RBITS_W'(12);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WINDOW_LENGTH: win_len_q   <= cfg_data_i;
        REG_FAST_MASK:     fast_mask_q <= cfg_data_i[MASK_W-1:0];
        REG_ENABLED_MASK:  en_mask_q   <= cfg_data_i[MASK_W-1:0];
        REG_RESULT_BITS:   rbits_q     <= cfg_data_i[RBITS_W-1:0];
        default: ;
      endcase
    end
  end

  seq_state_e state_q, state_d;

  logic [CH_W-1:0]    ch_q;
  logic [SMP_W-1:0]   smp_q;
  chan_entry_t        tbl_q [CHANNELS];
  logic [CI_W-1:0]    idx;
  chan_entry_t        ent;
  logic               hit;
  logic [WIN_W-1:0]   win;
  logic [WIN_W-1:0]   win_clamp;
  logic [RBITS_W-1:0] rb_clamp;
  logic [RED_W-1:0]   red;
  logic [SUM_W:0]     sum_wide;
  chan_entry_t        acc_ent;

  logic [CH_W-1:0]    res_ch_q;
  logic [SUM_W-1:0]   res_sum_q;
  logic [RED_W-1:0]   res_rng_q;
  logic [RBITS_W-1:0] shift_q;
  logic [WIN_W-1:0]   div_q;
  logic [WIN_W-1:0]   rem_q;
  logic [QUO_W-1:0]   quo_q;
  logic [STEP_W-1:0]  step_q;
  logic [WIN_W:0]     trial;
  logic               trial_ge;
  logic [RD_W-1:0]    quo_sat;

  out_word_t          out_word_q;
  logic               out_valid_q;

  // control strobes from the sequencer
  logic tbl_acc, tbl_reload, rslt_ld, div_step, out_ld;

  assign idx = CI_W'(ch_q);
  assign ent = tbl_q[idx];
  assign hit = (int'(ch_q) < CHANNELS) && en_mask_q[ch_q];

  always_comb begin
    win_clamp = win_len_q;
    if (win_len_q == '0) begin
      win_clamp = WIN_W'(1);
    end else if (int'(win_len_q) > MAX_WINDOW) begin
      win_clamp = WIN_W'(MAX_WINDOW);
    end
    win = fast_mask_q[ch_q] ? WIN_W'(1) : win_clamp;
    rb_clamp = rbits_q;
    if (rbits_q == '0) begin
      rb_clamp = RBITS_W'(1);
    end else if (rbits_q > RBITS_MAX) begin
      rb_clamp = RBITS_MAX;
    end
  end

  // accumulate path: saturating add and min/max of the top 8 sample bits
  always_comb begin
    red      = smp_q[SMP_W-1 -: RED_W];
    sum_wide = {1'b0, ent.sum} + (SUM_W+1)'(smp_q);
    acc_ent.count = ent.count - WIN_W'(1);
    acc_ent.sum   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    acc_ent.high  = (red > ent.high) ? red : ent.high;
    acc_ent.low   = (red < ent.low) ? red : ent.low;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (hit && ent.count == '0) state_d = ST_DIV;
        else state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (step_q == STEP_W'(QUO_W - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    tbl_acc    = 1'b0;
    tbl_reload = 1'b0;
    rslt_ld    = 1'b0;
    div_step   = 1'b0;
    out_ld     = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_LOOK: begin
        if (hit) begin
          if (ent.count != '0) begin
            tbl_acc = 1'b1;
          end else begin
            tbl_reload = 1'b1;
            rslt_ld    = 1'b1;
          end
        end
      end
      ST_DIV:  div_step = 1'b1;
      ST_DONE: out_ld = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q  <= in_word_i.channel;
      smp_q <= in_word_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        tbl_q[i] <= ENTRY_CLEAR;
      end
    end else if (tbl_acc) begin
      tbl_q[idx] <= acc_ent;
    end else if (tbl_reload) begin
      tbl_q[idx] <= '{count: win, sum: '0, high: '0, low: '1};
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem_q, quo_q[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (rslt_ld) begin
      res_ch_q  <= ch_q;
      res_sum_q <= ent.sum;
      res_rng_q <= (ent.high >= ent.low) ? (ent.high - ent.low) : '0;
      shift_q   <= RBITS_MAX - rb_clamp;
      div_q     <= win;
      rem_q     <= '0;
      quo_q     <= {ent.sum, 2'b00};
      step_q    <= '0;
    end else if (div_step) begin
      rem_q  <= trial_ge ? WIN_W'(trial - {1'b0, div_q}) : trial[WIN_W-1:0];
      quo_q  <= {quo_q[QUO_W-2:0], trial_ge};
      step_q <= step_q + STEP_W'(1);
    end
  end

  assign quo_sat = (quo_q > QUO_W'(RD_MAX)) ? RD_MAX : quo_q[RD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_word_q.out_channel    <= res_ch_q;
      out_word_q.window_sum     <= res_sum_q;
      out_word_q.scaled_reading <= quo_sat >> shift_q;
      out_word_q.sample_range   <= res_rng_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== bench/tb_multichannel_adc_oversampler.sv =====
// Self-checking bench for multichannel_adc_oversampler: a directed table, then random
// register settings, samples and gaps, checked against typed-in or predicted readings.
// Depends on mcao_pkg and the oversampler RTL.
`timescale 1ns / 1ps

module tb_multichannel_adc_oversampler;
  import mcao_pkg::*;

  localparam int unsigned N_CH          = 8;
  localparam int unsigned N_WIN         = 256;
  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned N_PHASES      = 12;
  localparam int unsigned PHASE_WORDS   = 140;
  localparam int unsigned SUM_CAP       = (1 << SUM_W) - 1;
  localparam int unsigned RD_CAP        = (1 << RD_W) - 1;

  // directed stimulus: register setting group, input word, typed-in reading if any
  typedef struct packed {
    logic [1:0] phase;
    in_word_t   word;
    logic       typed;
    out_word_t  want;
  } stim_row_t;

  localparam int N_ROWS = 25;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // all channels disabled out of reset
    '{2'd0, '{3'd0, 12'hFFF}, 1'b0, '0},
    '{2'd0, '{3'd7, 12'h000}, 1'b0, '0},
    // first word on a channel closes its empty window with an all-zero reading
    '{2'd1, '{3'd0, 12'hFFF}, 1'b1, '{3'd0, 20'd0, 14'd0, 8'd0}},
    '{2'd1, '{3'd0, 12'hFFF}, 1'b0, '0},
    '{2'd1, '{3'd0, 12'h000}, 1'b0, '0},
    '{2'd1, '{3'd0, 12'h123}, 1'b1, '{3'd0, 20'd4095, 14'd8190, 8'd255}},
    '{2'd1, '{3'd1, 12'h800}, 1'b1, '{3'd1, 20'd0, 14'd0, 8'd0}},
    '{2'd1, '{3'd1, 12'hFFF}, 1'b0, '0},
    '{2'd1, '{3'd1, 12'h555}, 1'b1, '{3'd1, 20'd4095, 14'd16380, 8'd0}},
    '{2'd1, '{3'd2, 12'hABC}, 1'b0, '0},
    '{2'd1, '{3'd7, 12'h001}, 1'b1, '{3'd7, 20'd0, 14'd0, 8'd0}},
    '{2'd1, '{3'd7, 12'h00F}, 1'b0, '0},
    '{2'd1, '{3'd7, 12'h010}, 1'b0, '0},
    '{2'd1, '{3'd7, 12'h7FF}, 1'b0, '0},
    // window shrinks to one mid-window: quotient clips, one result bit left
    '{2'd2, '{3'd0, 12'hFFF}, 1'b0, '0},
    '{2'd2, '{3'd0, 12'hFFF}, 1'b0, '0},
    '{2'd2, '{3'd0, 12'h000}, 1'b1, '{3'd0, 20'd8190, 14'd1, 8'd0}},
    '{2'd2, '{3'd7, 12'h800}, 1'b0, '0},
    '{2'd2, '{3'd1, 12'hFFF}, 1'b0, '0},
    '{2'd2, '{3'd7, 12'h7FF}, 1'b0, '0},
    '{2'd2, '{3'd7, 12'h001}, 1'b0, '0},
    // oversized window length and result bits
    '{2'd3, '{3'd0, 12'h7FF}, 1'b0, '0},
    '{2'd3, '{3'd0, 12'h000}, 1'b0, '0},
    '{2'd3, '{3'd3, 12'hFFF}, 1'b1, '{3'd3, 20'd0, 14'd0, 8'd0}},
    '{2'd3, '{3'd6, 12'h000}, 1'b1, '{3'd6, 20'd0, 14'd0, 8'd0}}
  };

  // per group: window_length, fast_channel_mask, enabled_mask, result_bits (raw writes)
  localparam logic [CFG_W-1:0] DIR_CFG [4][4] = '{
    '{9'd1,   9'h000, 9'h000, 9'd12},
    '{9'd2,   9'h002, 9'h083, 9'd14},
    '{9'd0,   9'h100, 9'h081, 9'd0},
    '{9'd511, 9'h000, 9'h0FF, 9'd15}
  };

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_word  = '0;
  logic      out_ready = 1'b0;
  logic      cfg_we   = 1'b0;
  logic [IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_word;

  multichannel_adc_oversampler #(
    .CHANNELS   (N_CH),
    .MAX_WINDOW (N_WIN)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state
  logic [WIN_W-1:0]   count_m [N_CH];
  logic [SUM_W-1:0]   sum_m   [N_CH];
  logic [RED_W-1:0]   high_m  [N_CH];
  logic [RED_W-1:0]   low_m   [N_CH];
  logic [WIN_W-1:0]   win_len_m = 9'd1;
  logic [MASK_W-1:0]  fast_m    = '0;
  logic [MASK_W-1:0]  en_m      = '0;
  logic [RBITS_W-1:0] rbits_m   = 4'd12;

  out_word_t pending_readings [$];
  int err_count     = 0;
  int words_sent    = 0;
  int readings_seen = 0;
  int settings_used = 0;
  int tx_gap_pct    = 0;
  int rx_stall_pct  = 0;
  int hold_after    = 32'h7FFF_FFFF;
  bit hold_done     = 1'b0;

  // Advances the channel model by one word; returns 1 with the reading when a window closes.
  function automatic bit predict_window_end(input in_word_t w, output out_word_t res);
    int unsigned win, quo, bits, acc;
    logic [CH_W-1:0] ch;
    logic [RED_W-1:0] top;
    res = '0;
    ch  = w.channel;
    if (!en_m[ch]) return 1'b0;
    if (count_m[ch] != 0) begin
      top = w.sample[SMP_W-1 -: RED_W];
      count_m[ch] = count_m[ch] - 1'b1;
      acc = 32'(sum_m[ch]) + 32'(w.sample);
      sum_m[ch] = (acc > SUM_CAP) ? SUM_W'(SUM_CAP) : SUM_W'(acc);
      if (top > high_m[ch]) high_m[ch] = top;
      if (top < low_m[ch]) low_m[ch] = top;
      return 1'b0;
    end
    if (fast_m[ch]) win = 1;
    else if (win_len_m == 0) win = 1;
    else if (win_len_m > N_WIN) win = N_WIN;
    else win = 32'(win_len_m);
    quo = (32'(sum_m[ch]) << 2) / win;
    if (quo > RD_CAP) quo = RD_CAP;
    if (rbits_m == 0) bits = 1;
    else if (rbits_m > RD_W) bits = RD_W;
    else bits = 32'(rbits_m);
    quo = quo >> (RD_W - bits);
    res.out_channel    = w.channel;
    res.window_sum     = sum_m[ch];
    res.scaled_reading = RD_W'(quo);
    res.sample_range   = (high_m[ch] >= low_m[ch]) ? high_m[ch] - low_m[ch] : '0;
    count_m[ch] = WIN_W'(win);
    sum_m[ch]   = '0;
    high_m[ch]  = '0;
    low_m[ch]   = '1;
    return 1'b1;
  endfunction

  task automatic offer_sample(input in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_burst(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // called at the edge that took the word
  task automatic account_sample(input in_word_t w, input bit typed, input out_word_t typed_want);
    out_word_t model;
    bit fires;
    if (en_m[w.channel]) words_sent++;
    fires = predict_window_end(w, model);
    if (typed) pending_readings.push_back(typed_want);
    else if (fires) pending_readings.push_back(model);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_WINDOW_LENGTH: win_len_m = val[WIN_W-1:0];
      REG_FAST_MASK:     fast_m    = val[MASK_W-1:0];
      REG_ENABLED_MASK:  en_m      = val[MASK_W-1:0];
      REG_RESULT_BITS:   rbits_m   = val[RBITS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [CFG_W-1:0] wl, input logic [CFG_W-1:0] fm,
                              input logic [CFG_W-1:0] em, input logic [CFG_W-1:0] rb);
    write_reg(REG_WINDOW_LENGTH, wl);
    write_reg(REG_FAST_MASK, fm);
    write_reg(REG_ENABLED_MASK, em);
    write_reg(REG_RESULT_BITS, rb);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // block must be idle before registers move: all readings out, divider quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_reading(input out_word_t got);
    out_word_t want;
    readings_seen++;
    if (pending_readings.size() == 0) begin
      $error("unexpected word on channel %0d, sum %0d", got.out_channel, got.window_sum);
      err_count++;
      return;
    end
    want = pending_readings.pop_front();
    if (got.out_channel !== want.out_channel) begin
      $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
      err_count++;
    end
    if (got.window_sum !== want.window_sum) begin
      $error("window_sum: expected %0d, got %0d", want.window_sum, got.window_sum);
      err_count++;
    end
    if (got.scaled_reading !== want.scaled_reading) begin
      $error("scaled_reading: expected %0d, got %0d", want.scaled_reading, got.scaled_reading);
      err_count++;
    end
    if (got.sample_range !== want.sample_range) begin
      $error("sample_range: expected %0d, got %0d", want.sample_range, got.sample_range);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_reading(out_word);
  end

  // receiver: random stall bursts, plus one long hold-off so the input backs up
  initial begin
    @(posedge rst_n);
    forever begin
      if (!hold_done && words_sent >= hold_after) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (cfg_we || (in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet = 0;
      else quiet++;
    end
    $error("no handshake for %0d cycles, %0d readings outstanding",
           STALL_LIMIT, pending_readings.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int cur_phase, phase_words;
    in_word_t w;
    logic [CFG_W-1:0] wl;
    logic [MASK_W-1:0] fm, em;
    logic [RBITS_W-1:0] rb;

    for (int c = 0; c < N_CH; c++) begin
      count_m[c] = '0;
      sum_m[c]   = '0;
      high_m[c]  = '0;
      low_m[c]   = '1;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    cur_phase    = 0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].phase != cur_phase) begin
        drain_and_settle();
        cur_phase = int'(DIRECTED[i].phase);
        write_config(DIR_CFG[cur_phase][0], DIR_CFG[cur_phase][1],
                     DIR_CFG[cur_phase][2], DIR_CFG[cur_phase][3]);
      end
      if ($urandom_range(0, 99) < tx_gap_pct) idle_burst($urandom_range(1, 18));
      offer_sample(DIRECTED[i].word);
      account_sample(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_and_settle();
      case ($urandom_range(0, 7))
        0: wl = 9'd0;
        1: wl = 9'd1;
        2: wl = 9'(N_WIN);
        3: wl = 9'($urandom_range(N_WIN + 1, 511));
        default: wl = 9'($urandom_range(2, 6));
      endcase
      fm = 8'($urandom);
      em = 8'($urandom);
      case ($urandom_range(0, 5))
        0: fm = '0;
        1: fm = '1;
        2: em = '1;
        default: ;
      endcase
      if (em == 0) em = 8'h01 << $urandom_range(0, 7);
      rb = 4'($urandom_range(0, 15));
      // one-word windows everywhere: a reading every other word fills the output side
      if (p == 2) begin
        fm = '1;
        em = '1;
      end
      if (p == N_PHASES - 1) wl = 9'($urandom_range(1, 4));
      write_config(wl, {1'($urandom), fm}, {1'($urandom), em}, {5'($urandom), rb});
      if (p == 2) hold_after = words_sent + 20;

      if (p == N_PHASES - 1 || p % 3 == 0) begin
        tx_gap_pct   = 0;
        rx_stall_pct = (p == N_PHASES - 1) ? 0 : $urandom_range(10, 50);
      end else begin
        tx_gap_pct   = $urandom_range(10, 50);
        rx_stall_pct = $urandom_range(0, 50);
      end

      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 85) begin
          do w.channel = 3'($urandom_range(0, 7)); while (!en_m[w.channel]);
        end else begin
          w.channel = 3'($urandom_range(0, 7));
        end
        case ($urandom_range(0, 9))
          0: w.sample = '0;
          1: w.sample = '1;
          default: w.sample = 12'($urandom);
        endcase
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
          idle_burst($urandom_range(1, 18));
        offer_sample(w);
        if (en_m[w.channel]) phase_words++;
        account_sample(w, 1'b0, '0);
      end
    end

    drain_and_settle();

    $display("Sent %0d words on enabled channels, checked %0d readings", words_sent,
             readings_seen);
    $display("over %0d register settings, with a %0d-cycle output hold-off", settings_used,
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
